[hw/rtl/tccw_pkg.sv]
// Shared types, constants and codes of the text console cell writer.
// Used by every module of the block; depends on nothing.

package tccw_pkg;

    // Screen geometry and tab spacing. TAB_STOP must be a power of two.
    localparam int MAX_COLUMNS = 80;
    localparam int MAX_ROWS    = 25;
    localparam int TAB_STOP    = 4;

    localparam int CELLS   = MAX_COLUMNS * MAX_ROWS;
    localparam int ADDR_W  = $clog2(CELLS);
    localparam int TOTAL_W = $clog2(CELLS + 1);

    // Field widths.
    localparam int KIND_W  = 2;
    localparam int CHAR_W  = 8;
    localparam int COORD_W = 8;
    localparam int COL_W   = 7;
    localparam int ROW_W   = 5;
    localparam int COLOR_W = 8;
    localparam int CELL_W  = 16;

    localparam int TAB_BITS   = $clog2(TAB_STOP);
    localparam int CNT_W      = $clog2(TAB_STOP + 1);
    localparam int PUT_LIN_W  = ROW_W + COL_W + 1;
    localparam int READ_LIN_W = COORD_W + COL_W + 1;

    // Configuration port.
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    // Control characters.
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'd10;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;

    // Register reset values.
    localparam logic [COLOR_W-1:0] RESET_COLOR   = 8'd7;
    localparam logic [COL_W-1:0]   RESET_COLUMNS = 7'd80;
    localparam logic [ROW_W-1:0]   RESET_ROWS    = 5'd25;
    localparam logic [CELL_W-1:0]  RESET_CELL    = {RESET_COLOR, 8'h00};

    typedef enum logic [KIND_W-1:0] {
        KIND_PUT   = 2'd0,
        KIND_CLEAR = 2'd1,
        KIND_READ  = 2'd2,
        KIND_NONE  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        REG_TEXT_COLOR     = 2'd0,
        REG_SCREEN_COLUMNS = 2'd1,
        REG_SCREEN_ROWS    = 2'd2,
        REG_ECHO_ENABLE    = 2'd3
    } t_reg_idx;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_DECODE,
        S_PUT,
        S_SCROLL,
        S_BLANK,
        S_CLEAR,
        S_READ,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [CHAR_W-1:0]  char_code;
        logic [COORD_W-1:0] read_column;
        logic [COORD_W-1:0] read_row;
    } t_in_item;

    typedef struct packed {
        logic [COL_W-1:0]  cursor_column;
        logic [ROW_W-1:0]  cursor_row;
        logic [CELL_W-1:0] cell_value;
        logic              echo_valid;
        logic [CHAR_W-1:0] echo_char;
        logic              last_of_run;
    } t_out_item;

    // Effective screen settings after clamping.
    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic [COL_W-1:0]   cols;
        logic [ROW_W-1:0]   rows;
        logic [TOTAL_W-1:0] total;
        logic               echo;
    } t_cfg;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [CELL_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;

endpackage

[hw/rtl/text_console_cell_writer.sv]
// Top level of the text console cell writer: channel handshakes and result register.
// Depends on tccw_pkg, tccw_cfg_regs, tccw_screen_ram and tccw_seq.
//
//   Port group        Direction  Transfer condition
//   i_in_*/o_in_stall  in         i_in_valid high and o_in_stall low at a rising edge
//   o_out_*/i_out_stall out       o_out_valid high and i_out_stall low at a rising edge
//   psel..pready       cfg        psel, penable, pwrite and pready high at a rising edge
//
// A plain put, newline or return passes the decode, put and emit states, a read
// decode, read and emit, an unused kind decode and emit; a tab repeats put and emit
// for each space. A scroll copies every row but the top one up by one row through the
// read and write ports of the screen memory, then blanks the bottom row; a clear
// blanks every cell of the active screen. After reset the screen memory is filled with
// the reset cell while o_in_stall stays high; configuration writes are taken throughout.
// A held i_out_stall keeps the finished result in the output register; the sequencer
// then waits before issuing the next result, and input is stalled until the item ends.

module text_console_cell_writer (
    input  logic                              i_clk,
    input  logic                              i_rst_n,

    input  logic                              i_in_valid,
    input  tccw_pkg::t_in_item                i_in_data,
    output logic                              o_in_stall,

    output logic                              o_out_valid,
    output tccw_pkg::t_out_item               o_out_data,
    input  logic                              i_out_stall,

    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tccw_pkg::PADDR_W-1:0]      paddr,
    input  logic [tccw_pkg::PDATA_W-1:0]      pwdata,
    output logic [tccw_pkg::PDATA_W-1:0]      prdata,
    output logic                              pready
);

    tccw_pkg::t_cfg              cfg;
    tccw_pkg::t_mem_req          mem_req;
    logic [tccw_pkg::CELL_W-1:0] mem_rdata;
    tccw_pkg::t_out_item         seq_res;
    logic                        seq_res_valid;
    logic                        seq_busy;
    logic                        in_accept;
    logic                        emit_ok;

    logic                        r_out_valid, n_out_valid;
    tccw_pkg::t_out_item         r_out_data, n_out_data;

    // The APB side never inserts wait states.
    assign pready = 1'b1;

    tccw_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .o_cfg   (cfg)
    );

    tccw_screen_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    // An input transfer is taken only while the sequencer waits for work.
    assign o_in_stall = seq_busy;
    assign in_accept  = i_in_valid && !seq_busy;

    // A new result may enter the output register when it is empty or being drained.
    assign emit_ok = !r_out_valid || !i_out_stall;

    tccw_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_accept    (in_accept),
        .i_item      (i_in_data),
        .o_busy      (seq_busy),
        .i_emit_ok   (emit_ok),
        .o_res_valid (seq_res_valid),
        .o_res       (seq_res),
        .o_mem_req   (mem_req),
        .i_rdata     (mem_rdata)
    );

    // Output register: holds a result until the downstream side takes it.
    always_comb begin
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        if (seq_res_valid) begin
            n_out_valid = 1'b1;
            n_out_data  = seq_res;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

[hw/rtl/tccw_screen_ram.sv]
// Screen cell memory: one write port and one read port with registered read data.
// Depends on tccw_pkg for geometry and the request struct.

module tccw_screen_ram (
    input  logic                              i_clk,
    input  tccw_pkg::t_mem_req                i_req,
    output logic [tccw_pkg::CELL_W-1:0]       o_rdata
);

    logic [tccw_pkg::CELL_W-1:0] r_mem [tccw_pkg::CELLS];
    logic [tccw_pkg::CELL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/tccw_cfg_regs.sv]
// Configuration registers behind the APB-style port, with clamped screen settings.
// Depends on tccw_pkg for widths, reset values and register indexes.

module tccw_cfg_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tccw_pkg::PADDR_W-1:0]      paddr,
    input  logic [tccw_pkg::PDATA_W-1:0]      pwdata,
    output logic [tccw_pkg::PDATA_W-1:0]      prdata,
    output tccw_pkg::t_cfg                    o_cfg
);

    localparam int CW = tccw_pkg::COL_W;
    localparam int RW = tccw_pkg::ROW_W;
    localparam int TW = tccw_pkg::TOTAL_W;
    localparam int DW = tccw_pkg::PDATA_W;

    logic [tccw_pkg::COLOR_W-1:0] r_color;
    logic [CW-1:0]                r_cols;
    logic [RW-1:0]                r_rows;
    logic                         r_echo;

    tccw_pkg::t_reg_idx idx;
    logic               wr_en;
    logic [CW-1:0]      cols_eff;
    logic [RW-1:0]      rows_eff;

    assign idx   = tccw_pkg::t_reg_idx'(paddr[tccw_pkg::PADDR_W-1:2]);
    assign wr_en = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color <= tccw_pkg::RESET_COLOR;
            r_cols  <= tccw_pkg::RESET_COLUMNS;
            r_rows  <= tccw_pkg::RESET_ROWS;
            r_echo  <= 1'b0;
        end else if (wr_en) begin
            case (idx)
                tccw_pkg::REG_TEXT_COLOR:     r_color <= pwdata[tccw_pkg::COLOR_W-1:0];
                tccw_pkg::REG_SCREEN_COLUMNS: r_cols  <= pwdata[CW-1:0];
                tccw_pkg::REG_SCREEN_ROWS:    r_rows  <= pwdata[RW-1:0];
                tccw_pkg::REG_ECHO_ENABLE:    r_echo  <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            tccw_pkg::REG_TEXT_COLOR:     prdata = DW'(r_color);
            tccw_pkg::REG_SCREEN_COLUMNS: prdata = DW'(r_cols);
            tccw_pkg::REG_SCREEN_ROWS:    prdata = DW'(r_rows);
            tccw_pkg::REG_ECHO_ENABLE:    prdata = DW'(r_echo);
            default:                      prdata = '0;
        endcase
    end

    // Zero counts as one, anything above the maximum counts as the maximum.
    always_comb begin
        if (r_cols == '0) begin
            cols_eff = CW'(1);
        end else if (r_cols > CW'(tccw_pkg::MAX_COLUMNS)) begin
            cols_eff = CW'(tccw_pkg::MAX_COLUMNS);
        end else begin
            cols_eff = r_cols;
        end
        if (r_rows == '0) begin
            rows_eff = RW'(1);
        end else if (r_rows > RW'(tccw_pkg::MAX_ROWS)) begin
            rows_eff = RW'(tccw_pkg::MAX_ROWS);
        end else begin
            rows_eff = r_rows;
        end
    end

    assign o_cfg.color = r_color;
    assign o_cfg.cols  = cols_eff;
    assign o_cfg.rows  = rows_eff;
    assign o_cfg.total = TW'(rows_eff) * TW'(cols_eff);
    assign o_cfg.echo  = r_echo;

endmodule

[hw/rtl/tccw_seq.sv]
// Sequencer: cursor state and the read-modify-write passes over the screen memory.
// Depends on tccw_pkg; drives tccw_screen_ram through a t_mem_req struct.

module tccw_seq (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  tccw_pkg::t_cfg                    i_cfg,
    input  logic                              i_accept,
    input  tccw_pkg::t_in_item                i_item,
    output logic                              o_busy,
    input  logic                              i_emit_ok,
    output logic                              o_res_valid,
    output tccw_pkg::t_out_item               o_res,
    output tccw_pkg::t_mem_req                o_mem_req,
    input  logic [tccw_pkg::CELL_W-1:0]       i_rdata
);

    localparam int AW  = tccw_pkg::ADDR_W;
    localparam int TW  = tccw_pkg::TOTAL_W;
    localparam int CW  = tccw_pkg::COL_W;
    localparam int RW  = tccw_pkg::ROW_W;
    localparam int NW  = tccw_pkg::CNT_W;
    localparam int PLW = tccw_pkg::PUT_LIN_W;
    localparam int RLW = tccw_pkg::READ_LIN_W;

    tccw_pkg::t_state            r_state, n_state;
    tccw_pkg::t_in_item          r_item, n_item;
    logic [CW-1:0]               r_col, n_col;
    logic [RW-1:0]               r_line, n_line;
    logic [NW-1:0]               r_count, n_count;
    logic [tccw_pkg::CHAR_W-1:0] r_echo, n_echo;
    logic [AW-1:0]               r_addr, n_addr;
    logic [TW-1:0]               r_rd, n_rd;
    logic                        r_wb_valid, n_wb_valid;
    logic [AW-1:0]               r_wb_addr, n_wb_addr;
    logic [tccw_pkg::CELL_W-1:0] r_cell, n_cell;
    logic                        r_rd_ok, n_rd_ok;

    tccw_pkg::t_kind             item_kind;
    logic                        item_is_put;
    logic                        put_is_lf, put_is_cr, put_stores, put_inside;
    logic [PLW-1:0]              put_lin;
    logic [RLW-1:0]              read_lin;
    logic                        read_inside;
    logic [CW:0]                 mv_col;
    logic [RW:0]                 mv_line;
    logic                        mv_scroll;
    logic [tccw_pkg::CELL_W-1:0] blank_cell;

    assign item_kind   = tccw_pkg::t_kind'(r_item.kind);
    assign item_is_put = (item_kind == tccw_pkg::KIND_PUT);
    assign blank_cell  = {i_cfg.color, 8'h00};

    assign put_is_lf  = (r_echo == tccw_pkg::CH_LF);
    assign put_is_cr  = (r_echo == tccw_pkg::CH_CR);
    assign put_stores = !put_is_lf && !put_is_cr;
    assign put_inside = (r_col < i_cfg.cols) && (r_line < i_cfg.rows);
    assign put_lin    = PLW'(r_line) * PLW'(i_cfg.cols) + PLW'(r_col);

    assign read_inside = (r_item.read_column < tccw_pkg::COORD_W'(i_cfg.cols)) &&
                         (r_item.read_row < tccw_pkg::COORD_W'(i_cfg.rows));
    assign read_lin    = RLW'(r_item.read_row) * RLW'(i_cfg.cols) + RLW'(r_item.read_column);

    // Cursor advance: wrap past the last column, clamp and scroll below the last row.
    always_comb begin
        if (put_is_lf) begin
            mv_col  = '0;
            mv_line = (RW+1)'(r_line) + (RW+1)'(1);
        end else if (put_is_cr) begin
            mv_col  = '0;
            mv_line = (RW+1)'(r_line);
        end else begin
            mv_col  = (CW+1)'(r_col) + (CW+1)'(1);
            mv_line = (RW+1)'(r_line);
        end
        if (mv_col >= (CW+1)'(i_cfg.cols)) begin
            mv_col  = '0;
            mv_line = mv_line + (RW+1)'(1);
        end
        mv_scroll = 1'b0;
        if (mv_line >= (RW+1)'(i_cfg.rows)) begin
            mv_line   = (RW+1)'(i_cfg.rows) - (RW+1)'(1);
            mv_scroll = 1'b1;
        end
    end

    always_comb begin
        o_res.cursor_column = r_col;
        o_res.cursor_row    = r_line;
        o_res.cell_value    = r_cell;
        o_res.echo_valid    = item_is_put && i_cfg.echo;
        o_res.echo_char     = item_is_put ? r_echo : '0;
        o_res.last_of_run   = item_is_put ? (r_count == NW'(1)) : 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= tccw_pkg::S_INIT;
            r_addr     <= '0;
            r_wb_valid <= 1'b0;
            r_count    <= '0;
            r_col      <= '0;
            r_line     <= '0;
        end else begin
            r_state    <= n_state;
            r_addr     <= n_addr;
            r_wb_valid <= n_wb_valid;
            r_count    <= n_count;
            r_col      <= n_col;
            r_line     <= n_line;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item    <= n_item;
        r_echo    <= n_echo;
        r_rd      <= n_rd;
        r_wb_addr <= n_wb_addr;
        r_cell    <= n_cell;
        r_rd_ok   <= n_rd_ok;
    end

    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_col       = r_col;
        n_line      = r_line;
        n_count     = r_count;
        n_echo      = r_echo;
        n_addr      = r_addr;
        n_rd        = r_rd;
        n_wb_valid  = r_wb_valid;
        n_wb_addr   = r_wb_addr;
        n_cell      = r_cell;
        n_rd_ok     = r_rd_ok;
        o_mem_req   = '0;
        o_res_valid = 1'b0;

        case (r_state)
            tccw_pkg::S_INIT: begin
                // Fill the whole memory with the reset cell after reset.
                o_mem_req.we    = 1'b1;
                o_mem_req.waddr = r_addr;
                o_mem_req.wdata = tccw_pkg::RESET_CELL;
                if (r_addr == AW'(tccw_pkg::CELLS - 1)) begin
                    n_addr  = '0;
                    n_state = tccw_pkg::S_IDLE;
                end else begin
                    n_addr = r_addr + AW'(1);
                end
            end
            tccw_pkg::S_IDLE: begin
                if (i_accept) begin
                    n_item  = i_item;
                    n_state = tccw_pkg::S_DECODE;
                end
            end
            tccw_pkg::S_DECODE: begin
                n_cell = '0;
                case (item_kind)
                    tccw_pkg::KIND_PUT: begin
                        if (r_item.char_code == tccw_pkg::CH_TAB) begin
                            n_count = NW'(tccw_pkg::TAB_STOP) -
                                      NW'(r_col[tccw_pkg::TAB_BITS-1:0]);
                            n_echo  = tccw_pkg::CH_SPACE;
                        end else begin
                            n_count = NW'(1);
                            n_echo  = r_item.char_code;
                        end
                        n_state = tccw_pkg::S_PUT;
                    end
                    tccw_pkg::KIND_CLEAR: begin
                        n_addr  = '0;
                        n_state = tccw_pkg::S_CLEAR;
                    end
                    tccw_pkg::KIND_READ: begin
                        o_mem_req.re    = read_inside;
                        o_mem_req.raddr = read_lin[AW-1:0];
                        n_rd_ok         = read_inside;
                        n_state         = tccw_pkg::S_READ;
                    end
                    default: begin
                        n_state = tccw_pkg::S_EMIT;
                    end
                endcase
            end
            tccw_pkg::S_PUT: begin
                o_mem_req.we    = put_stores && put_inside;
                o_mem_req.waddr = put_lin[AW-1:0];
                o_mem_req.wdata = {i_cfg.color, r_echo};
                n_col           = mv_col[CW-1:0];
                n_line          = mv_line[RW-1:0];
                if (mv_scroll) begin
                    n_rd       = TW'(i_cfg.cols);
                    n_wb_valid = 1'b0;
                    n_state    = tccw_pkg::S_SCROLL;
                end else begin
                    n_state = tccw_pkg::S_EMIT;
                end
            end
            tccw_pkg::S_SCROLL: begin
                // Read cell a, write it in the next cycle to a minus one row.
                if (r_wb_valid) begin
                    o_mem_req.we    = 1'b1;
                    o_mem_req.waddr = r_wb_addr;
                    o_mem_req.wdata = i_rdata;
                end
                if (r_rd < i_cfg.total) begin
                    o_mem_req.re    = 1'b1;
                    o_mem_req.raddr = r_rd[AW-1:0];
                    n_wb_valid      = 1'b1;
                    n_wb_addr       = AW'(r_rd - TW'(i_cfg.cols));
                    n_rd            = r_rd + TW'(1);
                end else begin
                    n_wb_valid = 1'b0;
                    n_addr     = AW'(i_cfg.total - TW'(i_cfg.cols));
                    n_state    = tccw_pkg::S_BLANK;
                end
            end
            tccw_pkg::S_BLANK: begin
                o_mem_req.we    = 1'b1;
                o_mem_req.waddr = r_addr;
                o_mem_req.wdata = blank_cell;
                if (TW'(r_addr) + TW'(1) >= i_cfg.total) begin
                    n_state = tccw_pkg::S_EMIT;
                end else begin
                    n_addr = r_addr + AW'(1);
                end
            end
            tccw_pkg::S_CLEAR: begin
                o_mem_req.we    = 1'b1;
                o_mem_req.waddr = r_addr;
                o_mem_req.wdata = blank_cell;
                if (TW'(r_addr) + TW'(1) >= i_cfg.total) begin
                    n_col   = '0;
                    n_line  = '0;
                    n_state = tccw_pkg::S_EMIT;
                end else begin
                    n_addr = r_addr + AW'(1);
                end
            end
            tccw_pkg::S_READ: begin
                n_cell  = r_rd_ok ? i_rdata : '0;
                n_state = tccw_pkg::S_EMIT;
            end
            tccw_pkg::S_EMIT: begin
                if (i_emit_ok) begin
                    o_res_valid = 1'b1;
                    if (item_is_put && (r_count > NW'(1))) begin
                        n_count = r_count - NW'(1);
                        n_state = tccw_pkg::S_PUT;
                    end else begin
                        n_state = tccw_pkg::S_IDLE;
                    end
                end
            end
            default: begin
                n_state = tccw_pkg::S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != tccw_pkg::S_IDLE);

    // Every put step has a nonzero count of characters or tab spaces left to write.
    a_put_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == tccw_pkg::S_PUT |-> r_count != '0)
        else $error("put step with no spaces left");

    // The reset fill leaves only after the last cell.
    a_init_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != tccw_pkg::S_INIT) && ($past(r_state) == tccw_pkg::S_INIT)
        |-> $past(r_addr) == AW'(tccw_pkg::CELLS - 1))
        else $error("reset fill ended early");

    // Only a tab yields results that are not the last of their item.
    a_run_tab: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !o_res.last_of_run
        |-> item_is_put && (r_item.char_code == tccw_pkg::CH_TAB))
        else $error("multi-result run from a non-tab item");

    // Clear homes the cursor.
    a_clear_home: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && (item_kind == tccw_pkg::KIND_CLEAR)
        |-> (o_res.cursor_column == '0) && (o_res.cursor_row == '0))
        else $error("clear result with cursor away from home");

endmodule

[sim/text_console_cell_writer_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for text_console_cell_writer: directed and random console traffic,
// checked result by result against a screen and cursor model kept inside this file.
// Depends on tccw_pkg and the text_console_cell_writer RTL.

module text_console_cell_writer_tb;
    import tccw_pkg::*;

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 4;
    // Longest quiet stretch of a correct run is the fill after reset or one full-screen
    // scroll, plus the long output hold-off. Several times that.
    localparam int QUIET_LIMIT  = 25000;
    localparam int SETTLE_CYCLES = 16;
    localparam int RESULT_SLOTS = 4;
    localparam int HOLDOFF_CYCLES = 150;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    t_in_item            in_data;
    logic                in_stall;
    logic                out_valid;
    t_out_item           out_data;
    logic                out_stall;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    text_console_cell_writer dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_data   (in_data),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_data  (out_data),
        .i_out_stall (out_stall),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial clk = 1'b0;
    always begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Console model: a flat copy of the screen memory, the cursor and the
    // four registers. Cells are addressed as row * columns + column with the
    // column count in force at the time of the access, exactly like the block,
    // so a change of geometry reinterprets the old contents the same way.
    // ------------------------------------------------------------------
    logic [CELL_W-1:0]  screen_shadow [CELLS];
    logic [COL_W-1:0]   cursor_col;
    logic [ROW_W-1:0]   cursor_row;
    logic [COLOR_W-1:0] color_reg;
    logic [COL_W-1:0]   columns_reg;
    logic [ROW_W-1:0]   rows_reg;
    logic               echo_reg;

    // Results still owed by the block, oldest first.
    t_out_item          owed_results[$];

    int unsigned        error_count;
    bit                 idle_on;         // random gaps on the input and stalls on the output
    int unsigned        hold_request;    // cycles of forced output stall, picked up once

    // A register value of zero counts as one, and a value beyond the memory as the maximum.
    function automatic int used_columns();
        if (columns_reg == 0) return 1;
        if (columns_reg > MAX_COLUMNS) return MAX_COLUMNS;
        return int'(columns_reg);
    endfunction

    function automatic int used_rows();
        if (rows_reg == 0) return 1;
        if (rows_reg > MAX_ROWS) return MAX_ROWS;
        return int'(rows_reg);
    endfunction

    // Writes outside the active screen are dropped and reads there give zero.
    function automatic void poke_cell(int col, int row, logic [CELL_W-1:0] value);
        if (col < used_columns() && row < used_rows())
            screen_shadow[row * used_columns() + col] = value;
    endfunction

    function automatic logic [CELL_W-1:0] peek_cell(int col, int row);
        if (col >= used_columns() || row >= used_rows()) return '0;
        return screen_shadow[row * used_columns() + col];
    endfunction

    function automatic void scroll_up();
        int nc;
        int nr;
        nc = used_columns();
        nr = used_rows();
        for (int r = 1; r < nr; r++)
            for (int c = 0; c < nc; c++)
                poke_cell(c, r - 1, peek_cell(c, r));
        for (int c = 0; c < nc; c++)
            poke_cell(c, nr - 1, {color_reg, 8'h00});
    endfunction

    // Past the last column wraps to the next row; past the last row pins the
    // cursor to the bottom row and scrolls the screen by one row.
    function automatic void move_cursor_to(int col, int row);
        if (col >= used_columns()) begin
            col = 0;
            row++;
        end
        if (row >= used_rows()) begin
            row = used_rows() - 1;
            scroll_up();
        end
        cursor_col = COL_W'(col);
        cursor_row = ROW_W'(row);
    endfunction

    function automatic void print_char(logic [CHAR_W-1:0] ch);
        poke_cell(int'(cursor_col), int'(cursor_row), {color_reg, ch});
        move_cursor_to(int'(cursor_col) + 1, int'(cursor_row));
    endfunction

    function automatic void owe_result(logic [CELL_W-1:0] cell_val, logic echo_on,
                                       logic [CHAR_W-1:0] echo_ch, logic last);
        t_out_item res;
        res.cursor_column = cursor_col;
        res.cursor_row    = cursor_row;
        res.cell_value    = cell_val;
        res.echo_valid    = echo_on;
        res.echo_char     = echo_ch;
        res.last_of_run   = last;
        owed_results.push_back(res);
    endfunction

    // Applies one accepted input item to the model and queues what it must produce.
    function automatic void apply_item(t_in_item it);
        int spaces;
        case (t_kind'(it.kind))
            KIND_CLEAR: begin
                for (int r = 0; r < used_rows(); r++)
                    for (int c = 0; c < used_columns(); c++)
                        poke_cell(c, r, {color_reg, 8'h00});
                move_cursor_to(0, 0);
                owe_result('0, 1'b0, '0, 1'b1);
            end
            KIND_READ: begin
                owe_result(peek_cell(int'(it.read_column), int'(it.read_row)),
                           1'b0, '0, 1'b1);
            end
            KIND_NONE: begin
                owe_result('0, 1'b0, '0, 1'b1);
            end
            default: begin
                if (it.char_code == CH_LF) begin
                    move_cursor_to(0, int'(cursor_row) + 1);
                    owe_result('0, echo_reg, CH_LF, 1'b1);
                end else if (it.char_code == CH_CR) begin
                    // A return on a row below a shrunk screen still scrolls.
                    move_cursor_to(0, int'(cursor_row));
                    owe_result('0, echo_reg, CH_CR, 1'b1);
                end else if (it.char_code == CH_TAB) begin
                    spaces = TAB_STOP - (int'(cursor_col) % TAB_STOP);
                    for (int k = 0; k < spaces; k++) begin
                        print_char(CH_SPACE);
                        // Spaces past the last result slot replace the one before.
                        if (k >= RESULT_SLOTS) void'(owed_results.pop_back());
                        owe_result('0, echo_reg, CH_SPACE, k + 1 == spaces);
                    end
                end else begin
                    print_char(it.char_code);
                    owe_result('0, echo_reg, it.char_code, 1'b1);
                end
            end
        endcase
    endfunction

    function automatic void check_field(string name, logic [CELL_W-1:0] want,
                                        logic [CELL_W-1:0] got);
        if (got !== want) begin
            error_count++;
            $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
        end
    endfunction

    // ------------------------------------------------------------------
    // Result checking and watchdog. Outputs are sampled at the rising edge,
    // before any update of that edge lands, so the values seen are the ones
    // the transfer was made with.
    // ------------------------------------------------------------------
    int unsigned quiet_cycles;

    always @(posedge clk) begin : result_check
        t_out_item want;
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                if (owed_results.size() == 0) begin
                    error_count++;
                    $display("%0t: result transfer with nothing owed, expected none, got %p",
                             $time, out_data);
                end else begin
                    want = owed_results.pop_front();
                    check_field("cursor_column", CELL_W'(want.cursor_column),
                                CELL_W'(out_data.cursor_column));
                    check_field("cursor_row", CELL_W'(want.cursor_row),
                                CELL_W'(out_data.cursor_row));
                    check_field("cell_value", want.cell_value, out_data.cell_value);
                    check_field("echo_valid", CELL_W'(want.echo_valid),
                                CELL_W'(out_data.echo_valid));
                    check_field("echo_char", CELL_W'(want.echo_char),
                                CELL_W'(out_data.echo_char));
                    check_field("last_of_run", CELL_W'(want.last_of_run),
                                CELL_W'(out_data.last_of_run));
                end
            end
            // Any transfer on either channel counts as progress.
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t: no transfer for %0d cycles, %0d results still owed",
                         $time, quiet_cycles, owed_results.size());
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output side. Stalls come in short random bursts while idling is on.
    // A hold-off request forces one long stall, counted here, so the block
    // backs up and stalls its own input.
    // ------------------------------------------------------------------
    initial begin : result_receiver
        int unsigned stall_left;
        stall_left = 0;
        out_stall  = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_request != 0) begin
                stall_left   = hold_request;
                hold_request = 0;
            end
            if (stall_left != 0) begin
                out_stall <= 1'b1;
                stall_left--;
            end else if (idle_on && $urandom_range(0, 9) == 0) begin
                out_stall <= 1'b1;
                stall_left = $urandom_range(0, 7);
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Input side and register access.
    // ------------------------------------------------------------------

    // Offers one item and returns at the edge of its transfer. Valid stays high
    // into the next call, so back-to-back items go out without a bubble.
    task automatic send_item(t_in_item it);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        apply_item(it);
    endtask

    function automatic t_in_item make_item(t_kind kind, logic [CHAR_W-1:0] ch,
                                           logic [COORD_W-1:0] col, logic [COORD_W-1:0] row);
        t_in_item it;
        it.kind        = kind;
        it.char_code   = ch;
        it.read_column = col;
        it.read_row    = row;
        return it;
    endfunction

    // Unused fields carry random bits; the block must ignore them.
    task automatic put_char(logic [CHAR_W-1:0] ch);
        send_item(make_item(KIND_PUT, ch, 8'($urandom), 8'($urandom)));
    endtask

    task automatic read_cell(int col, int row);
        send_item(make_item(KIND_READ, 8'($urandom), 8'(col), 8'(row)));
    endtask

    // Stops offering input, waits for every owed result, then lets the block
    // finish any memory pass before the registers may change.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (owed_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Setup cycle, then access cycle; the write lands at the edge with pready high.
    task automatic write_reg(t_reg_idx idx, logic [PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(int'(idx) * 4);
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_TEXT_COLOR:     color_reg   = value[COLOR_W-1:0];
            REG_SCREEN_COLUMNS: columns_reg = value[COL_W-1:0];
            REG_SCREEN_ROWS:    rows_reg    = value[ROW_W-1:0];
            REG_ECHO_ENABLE:    echo_reg    = value[0];
            default: ;
        endcase
    endtask

    task automatic set_geometry(int cols, int rows);
        write_reg(REG_SCREEN_COLUMNS, PDATA_W'(cols));
        write_reg(REG_SCREEN_ROWS, PDATA_W'(rows));
    endtask

    // Mostly printable text with line control mixed in, some reads (mostly
    // inside the screen), and rare clears and unused kinds.
    function automatic t_in_item random_item();
        t_in_item it;
        int pick;
        it.char_code   = 8'($urandom);
        it.read_column = 8'($urandom);
        it.read_row    = 8'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 3) begin
            it.kind = KIND_NONE;
        end else if (pick < 5) begin
            it.kind = KIND_CLEAR;
        end else if (pick < 20) begin
            it.kind = KIND_READ;
            if ($urandom_range(0, 3) != 0) begin
                it.read_column = 8'($urandom_range(0, used_columns() - 1));
                it.read_row    = 8'($urandom_range(0, used_rows() - 1));
            end
        end else begin
            it.kind = KIND_PUT;
            case ($urandom_range(0, 19))
                0, 1:    it.char_code = CH_LF;
                2:       it.char_code = CH_CR;
                3, 4:    it.char_code = CH_TAB;
                default: ;
            endcase
        end
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset geometry: the screen comes up as blank cells, printable bytes at
    // both ends of the range, control characters, reads at and beyond the
    // screen edge, the unused kind and a clear.
    task automatic test_default_screen();
        read_cell(0, 0);
        read_cell(MAX_COLUMNS - 1, MAX_ROWS - 1);
        put_char(8'h41);
        put_char(8'hFF);
        put_char(8'h00);
        put_char(8'h80);
        put_char(CH_TAB);
        put_char(8'h7F);
        put_char(CH_TAB);
        put_char(CH_CR);
        put_char(CH_LF);
        put_char(CH_TAB);
        read_cell(0, 0);
        read_cell(1, 0);
        read_cell(4, 0);
        read_cell(MAX_COLUMNS, 0);
        read_cell(0, MAX_ROWS);
        read_cell(255, 255);
        send_item(make_item(KIND_NONE, 8'hFF, 8'hFF, 8'hFF));
        send_item(make_item(KIND_CLEAR, 8'h00, 8'h00, 8'h00));
        read_cell(0, 0);
        read_cell(1, 0);
        settle();
    endtask

    // Register extremes: a zero-sized screen acts as one cell, oversized
    // values clamp to the memory size, and only the low bits of each write count.
    task automatic test_register_extremes();
        write_reg(REG_ECHO_ENABLE, 32'd1);
        write_reg(REG_TEXT_COLOR, 32'h0000_01FF);
        set_geometry(0, 0);
        put_char(8'h61);
        put_char(8'h62);
        read_cell(0, 0);
        read_cell(1, 0);
        put_char(CH_LF);
        put_char(CH_CR);
        put_char(CH_TAB);
        read_cell(0, 0);
        settle();

        write_reg(REG_SCREEN_COLUMNS, 32'hFFFF_FFFF);
        write_reg(REG_SCREEN_ROWS, 32'hFFFF_FFFF);
        write_reg(REG_TEXT_COLOR, 32'd0);
        write_reg(REG_ECHO_ENABLE, 32'hFFFF_FFFE);
        put_char(8'h71);
        read_cell(MAX_COLUMNS - 1, MAX_ROWS - 1);
        read_cell(MAX_COLUMNS, MAX_ROWS - 1);
        settle();

        // A 3 by 2 screen wraps and scrolls every few characters.
        write_reg(REG_ECHO_ENABLE, 32'd1);
        write_reg(REG_TEXT_COLOR, 32'h0000_005A);
        set_geometry(3, 2);
        repeat (7) put_char(8'($urandom_range(33, 126)));
        put_char(CH_TAB);
        read_cell(0, 0);
        read_cell(2, 1);
        read_cell(3, 1);
        settle();

        write_reg(REG_TEXT_COLOR, PDATA_W'(RESET_COLOR));
        write_reg(REG_ECHO_ENABLE, 32'd0);
        set_geometry(MAX_COLUMNS, MAX_ROWS);
    endtask

    // A cursor left outside a screen that was shrunk under it: a put stores
    // nothing and brings the cursor back with a scroll, a return scrolls too,
    // and a tab starting outside wraps before writing its spaces.
    task automatic test_cursor_outside();
        send_item(make_item(KIND_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom)));
        repeat (12) put_char(CH_LF);
        repeat (5) put_char(8'($urandom_range(65, 90)));
        settle();
        set_geometry(4, 3);
        put_char(8'h5A);
        read_cell(0, 2);
        read_cell(0, 1);
        read_cell(3, 0);
        settle();

        set_geometry(MAX_COLUMNS, MAX_ROWS);
        repeat (10) put_char(CH_LF);
        settle();
        set_geometry(MAX_COLUMNS, 3);
        put_char(CH_CR);
        put_char(8'h43);
        settle();

        set_geometry(MAX_COLUMNS, MAX_ROWS);
        repeat (8) put_char(8'($urandom_range(97, 122)));
        settle();
        write_reg(REG_SCREEN_COLUMNS, 32'd5);
        put_char(CH_TAB);
        read_cell(0, 3);
        read_cell(1, 3);
        settle();
        write_reg(REG_SCREEN_COLUMNS, PDATA_W'(MAX_COLUMNS));
    endtask

    // The receiver holds off for a long stretch while input keeps coming,
    // so the block backs up and stalls its input channel.
    task automatic test_output_holdoff();
        write_reg(REG_ECHO_ENABLE, 32'd1);
        set_geometry(10, 4);
        hold_request = HOLDOFF_CYCLES;
        repeat (6) put_char(8'($urandom_range(33, 126)));
        put_char(CH_TAB);
        repeat (5) send_item(random_item());
        settle();
    endtask

    // Random traffic over a series of random register settings. Most screens
    // are small so scrolls and clears stay cheap; now and then a large one.
    task automatic test_random_traffic();
        for (int phase = 0; phase < 4; phase++) begin
            write_reg(REG_TEXT_COLOR, $urandom);
            write_reg(REG_ECHO_ENABLE, $urandom);
            if ($urandom_range(0, 2) == 0)
                set_geometry($urandom_range(0, 127), $urandom_range(0, 31));
            else
                set_geometry($urandom_range(1, 16), $urandom_range(1, 8));
            repeat (32) send_item(random_item());
            settle();
        end
    endtask

    // Last stretch with no gaps and no stalls at all.
    task automatic test_steady_stream();
        idle_on = 1'b0;
        write_reg(REG_TEXT_COLOR, $urandom);
        write_reg(REG_ECHO_ENABLE, 32'd1);
        set_geometry(20, 6);
        repeat (30) send_item(random_item());
        settle();
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        in_valid     = 1'b0;
        in_data      = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        rst_n        = 1'b0;
        idle_on      = 1'b1;
        hold_request = 0;
        error_count  = 0;
        quiet_cycles = 0;

        for (int i = 0; i < CELLS; i++) screen_shadow[i] = RESET_CELL;
        cursor_col  = '0;
        cursor_row  = '0;
        color_reg   = RESET_COLOR;
        columns_reg = RESET_COLUMNS;
        rows_reg    = RESET_ROWS;
        echo_reg    = 1'b0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // The block fills its screen memory after reset with its input stalled;
        // the first transfer simply waits for that to finish.
        test_default_screen();
        test_register_extremes();
        test_cursor_outside();
        test_output_holdoff();
        test_random_traffic();
        test_steady_stream();

        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[files.f]
hw/rtl/tccw_pkg.sv
hw/rtl/tccw_screen_ram.sv
hw/rtl/tccw_cfg_regs.sv
hw/rtl/tccw_seq.sv
hw/rtl/text_console_cell_writer.sv
sim/text_console_cell_writer_tb.sv
